FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define GBWF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Signal that must be high in the cycle after the condition.
`define GBWF_ASSERT_HOLD(label, cond, sig, msg) \
	`GBWF_ASSERT(label, (cond) |=> (sig), msg)

`endif

FILE: src/gbwf_pkg.sv
// ----------------------------------------------------------------------------
// gbwf_pkg
// Shared types and constants for the Gaussian blur window filter.
// ----------------------------------------------------------------------------
package gbwf_pkg;

	localparam int RADIUS_DEF     = 3;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W  = 24;
	localparam int CH_W   = 8;
	localparam int COEF_W = 16;
	localparam int DIM_W  = 11;
	localparam int IDX_W  = 3;
	localparam int NCOEF  = 6;

	localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd1024;
	localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd1024;
	localparam logic [COEF_W-1:0] COEF0_RST  = 16'd26263;
	localparam logic [COEF_W-1:0] COEF1_RST  = 16'd15930;
	localparam logic [COEF_W-1:0] COEF2_RST  = 16'd3554;
	localparam logic [COEF_W-1:0] COEF3_RST  = 16'd291;
	localparam logic [COEF_W-1:0] COEF4_RST  = 16'd0;
	localparam logic [COEF_W-1:0] COEF5_RST  = 16'd0;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_COEF0  = 3'd2,
		REG_COEF1  = 3'd3,
		REG_COEF2  = 3'd4,
		REG_COEF3  = 3'd5,
		REG_COEF4  = 3'd6,
		REG_COEF5  = 3'd7
	} reg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic last_tap;
		logic out_busy;
	} status_t;

endpackage

FILE: src/gbwf_ctrl.sv
// ----------------------------------------------------------------------------
// gbwf_ctrl
// Sequencer: accepts a word and, when it yields a result, walks the window taps,
// waits out the MAC pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
module gbwf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  gbwf_pkg::status_t status,
	output gbwf_pkg::cmd_t    cmd
);

	gbwf_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbwf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx   = state_q;
		s_tready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			gbwf_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && status.emit) begin
					state_nx = gbwf_pkg::ST_CALC;
				end
			end
			gbwf_pkg::ST_CALC: begin
				cmd.step = 1'b1;
				if (status.last_tap) begin
					state_nx = gbwf_pkg::ST_DRAIN1;
				end
			end
			gbwf_pkg::ST_DRAIN1: state_nx = gbwf_pkg::ST_DRAIN2;
			gbwf_pkg::ST_DRAIN2: state_nx = gbwf_pkg::ST_FIN;
			gbwf_pkg::ST_FIN: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_nx   = gbwf_pkg::ST_IDLE;
				end
			end
			default: state_nx = gbwf_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: src/gbwf_datapath.sv
// ----------------------------------------------------------------------------
// gbwf_datapath
// Config registers, frame counters, line store, tap walker, MAC pipeline and
// output register.
// ----------------------------------------------------------------------------
module gbwf_datapath #(
	parameter int RADIUS     = gbwf_pkg::RADIUS_DEF,
	parameter int MAX_WIDTH  = gbwf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gbwf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [gbwf_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gbwf_pkg::COEF_W-1:0]   cfg_data,
	input  logic [gbwf_pkg::PIX_W-1:0]    s_tdata,
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gbwf_pkg::PIX_W-1:0]    m_tdata,
	output logic                          m_tlast,
	input  gbwf_pkg::cmd_t                cmd,
	output gbwf_pkg::status_t             status
);

	localparam int K     = 2 * RADIUS + 1;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int LW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1) + 1;
	localparam int DEPTH = K * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = $clog2(K);
	localparam int WTW   = 2 * gbwf_pkg::COEF_W;
	localparam int PW    = WTW + gbwf_pkg::CH_W;
	localparam int ACC_W = PW + $clog2(K * K);
	localparam int CH_W  = gbwf_pkg::CH_W;

	// config
	logic [gbwf_pkg::DIM_W-1:0]  width_q, height_q;
	logic [gbwf_pkg::COEF_W-1:0] coef_q [gbwf_pkg::NCOEF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= gbwf_pkg::WIDTH_RST;
			height_q  <= gbwf_pkg::HEIGHT_RST;
			coef_q[0] <= gbwf_pkg::COEF0_RST;
			coef_q[1] <= gbwf_pkg::COEF1_RST;
			coef_q[2] <= gbwf_pkg::COEF2_RST;
			coef_q[3] <= gbwf_pkg::COEF3_RST;
			coef_q[4] <= gbwf_pkg::COEF4_RST;
			coef_q[5] <= gbwf_pkg::COEF5_RST;
		end else if (cfg_valid) begin
			unique case (gbwf_pkg::reg_idx_t'(cfg_index))
				gbwf_pkg::REG_WIDTH:  width_q   <= cfg_data[gbwf_pkg::DIM_W-1:0];
				gbwf_pkg::REG_HEIGHT: height_q  <= cfg_data[gbwf_pkg::DIM_W-1:0];
				gbwf_pkg::REG_COEF0:  coef_q[0] <= cfg_data;
				gbwf_pkg::REG_COEF1:  coef_q[1] <= cfg_data;
				gbwf_pkg::REG_COEF2:  coef_q[2] <= cfg_data;
				gbwf_pkg::REG_COEF3:  coef_q[3] <= cfg_data;
				gbwf_pkg::REG_COEF4:  coef_q[4] <= cfg_data;
				gbwf_pkg::REG_COEF5:  coef_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective frame size
	logic [WW-1:0] w;
	logic [RW-1:0] h;
	logic [LW-1:0] lag;

	always_comb begin
		if (width_q == '0) w = WW'(1);
		else if (int'(width_q) > MAX_WIDTH) w = WW'(MAX_WIDTH);
		else w = WW'(width_q);
		if (height_q == '0) h = RW'(1);
		else if (int'(height_q) > MAX_HEIGHT) h = RW'(MAX_HEIGHT);
		else h = RW'(height_q);
		lag = LW'(w) * LW'(RADIUS) + LW'(RADIUS);
	end

	// frame counters; ptr is the linear pixel index wrapped at the store depth
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [AW-1:0] in_ptr_q, out_ptr_q;
	logic [LW-1:0] in_lin_q, out_lin_q;

	logic          clr;
	logic [CW-1:0] cin_col, cout_col;
	logic [RW-1:0] cin_row, cout_row;
	logic [AW-1:0] cin_ptr, cout_ptr;
	logic [LW-1:0] cin_lin, cout_lin;
	logic          is_pix, wr_en, emit;
	logic [CW-1:0] in_col_nx;
	logic [RW-1:0] in_row_nx;
	logic [AW-1:0] in_ptr_nx;
	logic [AW:0]   start_ptr;

	always_comb begin
		clr       = (in_row_q >= h) && (out_row_q >= h);
		cin_col   = clr ? '0 : in_col_q;
		cin_row   = clr ? '0 : in_row_q;
		cin_ptr   = clr ? '0 : in_ptr_q;
		cin_lin   = clr ? '0 : in_lin_q;
		cout_col  = clr ? '0 : out_col_q;
		cout_row  = clr ? '0 : out_row_q;
		cout_ptr  = clr ? '0 : out_ptr_q;
		cout_lin  = clr ? '0 : out_lin_q;
		is_pix    = gbwf_pkg::op_t'(s_tuser) == gbwf_pkg::OP_PIXEL;
		wr_en     = cmd.accept && is_pix && (cin_row < h);
		if ((WW + 1)'(cin_col) + (WW + 1)'(1) >= (WW + 1)'(w)) begin
			in_col_nx  = '0;
			in_row_nx  = cin_row + RW'(1);
		end else begin
			in_col_nx  = cin_col + CW'(1);
			in_row_nx  = cin_row;
		end
		in_ptr_nx = (int'(cin_ptr) == DEPTH - 1) ? '0 : cin_ptr + AW'(1);
		if (is_pix) begin
			emit = (cin_row < h) && (cout_row < h) && (cout_lin + lag < cin_lin + LW'(1));
		end else begin
			emit = (cin_row >= h) && (cout_row < h);
		end
		// window origin: RADIUS rows and RADIUS pixels before the output pixel
		start_ptr = (AW + 1)'(cout_ptr) + (AW + 1)'(DEPTH) - (AW + 1)'(lag);
		if (int'(start_ptr) >= DEPTH) start_ptr = start_ptr - (AW + 1)'(DEPTH);
	end

	// tap walker
	logic [TW-1:0] tr_q, tc_q;
	logic [AW-1:0] rd_ptr_q, rd_ptr_nx;
	logic [AW:0]   row_sum, rd_sum;
	logic [RW:0]   ys;
	logic [CW:0]   xs;
	logic          tap_ok;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [2:0]    ar, ac;
	logic          last_tap;

	always_comb begin
		ys      = (RW + 1)'(out_row_q) + (RW + 1)'(tr_q);
		xs      = (CW + 1)'(out_col_q) + (CW + 1)'(tc_q);
		tap_ok  = (ys >= (RW + 1)'(RADIUS)) && (ys - (RW + 1)'(RADIUS) < (RW + 1)'(h))
			&& (xs >= (CW + 1)'(RADIUS))
			&& ((WW + 2)'(xs - (CW + 1)'(RADIUS)) < (WW + 2)'(w));
		// next window row starts w - (K-1) pixels past the last tap, wrapped
		row_sum = (AW + 1)'(w) + (AW + 1)'(DEPTH) - (AW + 1)'(K - 1);
		if (int'(row_sum) >= DEPTH) row_sum = row_sum - (AW + 1)'(DEPTH);
		if (int'(tc_q) == K - 1) rd_sum = (AW + 1)'(rd_ptr_q) + row_sum;
		else rd_sum = (AW + 1)'(rd_ptr_q) + (AW + 1)'(1);
		if (int'(rd_sum) >= DEPTH) rd_sum = rd_sum - (AW + 1)'(DEPTH);
		rd_ptr_nx = AW'(rd_sum);
		rd_addr = rd_ptr_q;
		wr_addr = cin_ptr;
		ar      = (int'(tr_q) < RADIUS) ? 3'(RADIUS - int'(tr_q)) : 3'(int'(tr_q) - RADIUS);
		ac      = (int'(tc_q) < RADIUS) ? 3'(RADIUS - int'(tc_q)) : 3'(int'(tc_q) - RADIUS);
		last_tap = (int'(tr_q) == K - 1) && (int'(tc_q) == K - 1);
	end

	// output counter advance
	logic [CW-1:0] out_col_nx;
	logic [RW-1:0] out_row_nx;
	logic [AW-1:0] out_ptr_nx;

	always_comb begin
		if ((WW + 1)'(out_col_q) + (WW + 1)'(1) >= (WW + 1)'(w)) begin
			out_col_nx  = '0;
			out_row_nx  = out_row_q + RW'(1);
		end else begin
			out_col_nx  = out_col_q + CW'(1);
			out_row_nx  = out_row_q;
		end
		out_ptr_nx = (int'(out_ptr_q) == DEPTH - 1) ? '0 : out_ptr_q + AW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_ptr_q   <= '0;
			in_lin_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_ptr_q  <= '0;
			out_lin_q  <= '0;
			tr_q       <= '0;
			tc_q       <= '0;
			rd_ptr_q   <= '0;
		end else if (cmd.accept) begin
			out_col_q  <= cout_col;
			out_row_q  <= cout_row;
			out_ptr_q  <= cout_ptr;
			out_lin_q  <= cout_lin;
			if (wr_en) begin
				in_col_q  <= in_col_nx;
				in_row_q  <= in_row_nx;
				in_ptr_q  <= in_ptr_nx;
				in_lin_q  <= cin_lin + LW'(1);
			end else begin
				in_col_q  <= cin_col;
				in_row_q  <= cin_row;
				in_ptr_q  <= cin_ptr;
				in_lin_q  <= cin_lin;
			end
			tr_q       <= '0;
			tc_q       <= '0;
			rd_ptr_q   <= AW'(start_ptr);
		end else if (cmd.step) begin
			rd_ptr_q <= rd_ptr_nx;
			if (int'(tc_q) == K - 1) begin
				tc_q <= '0;
				tr_q <= tr_q + TW'(1);
			end else begin
				tc_q <= tc_q + TW'(1);
			end
		end else if (cmd.finish) begin
			if (out_row_nx >= h) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_ptr_q   <= '0;
				in_lin_q   <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_ptr_q  <= '0;
				out_lin_q  <= '0;
			end else begin
				out_col_q  <= out_col_nx;
				out_row_q  <= out_row_nx;
				out_ptr_q  <= out_ptr_nx;
				out_lin_q  <= out_lin_q + LW'(1);
			end
		end
	end

	// line store
	logic [gbwf_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= s_tdata;
		end
	end

	// MAC pipeline: s1 read + weight, s2 products, then accumulate
	logic                       v_s1, v_s2;
	logic [gbwf_pkg::PIX_W-1:0] rd_s1;
	logic [WTW-1:0]             wt_s1;
	logic [PW-1:0]              prod_s2 [3];
	logic [ACC_W-1:0]           acc_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.step && tap_ok;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && tap_ok) begin
			rd_s1 <= mem[rd_addr];
		end
		wt_s1 <= WTW'(coef_q[ar]) * WTW'(coef_q[ac]);
		for (int ch = 0; ch < 3; ch++) begin
			prod_s2[ch] <= PW'(rd_s1[ch*CH_W +: CH_W]) * PW'(wt_s1);
			if (cmd.accept) acc_q[ch] <= '0;
			else if (v_s2) acc_q[ch] <= acc_q[ch] + ACC_W'(prod_s2[ch]);
		end
	end

	// output register
	logic                       out_valid_q;
	logic [gbwf_pkg::PIX_W-1:0] out_data_q;
	logic                       out_last_q;
	logic [gbwf_pkg::PIX_W-1:0] sat;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			if (acc_q[ch][ACC_W-1:WTW] > (ACC_W - WTW)'(255)) sat[ch*CH_W +: CH_W] = 8'hFF;
			else sat[ch*CH_W +: CH_W] = acc_q[ch][WTW +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= sat;
			out_last_q <= out_row_nx >= h;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_data_q;
	assign m_tlast         = out_last_q;
	assign status.emit     = emit;
	assign status.last_tap = last_tap;
	assign status.out_busy = out_valid_q;

endmodule

FILE: src/gaussian_blur_window_filter.sv
// ----------------------------------------------------------------------------
// gaussian_blur_window_filter
// Streaming separable-weight Gaussian blur over RGB888 raster pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the s_ side; each result is the
// (2*RADIUS+1)^2 weighted window around one pixel, per channel, with weight
// coef[|r|]*coef[|c|] (Q0.16 x Q0.16), taps outside the frame skipped,
// floor(sum/2^32) saturated to 255. Results lag input by RADIUS rows plus
// RADIUS pixels; after the last pixel, flush words (tuser=1) drain the rest,
// and tlast marks the last result of the frame, after which counters restart.
// A word that yields no result leaves the block ready for the next word.
// For one that does, a MAC per channel walks the window one tap per cycle
// through the single read port of the line store; the MAC pipeline then
// drains (DRAIN1, DRAIN2) and the result goes to the output register. Input
// is taken again as soon as the result sits in the output register; a new
// result waits ahead of it only if the previous one has not been taken. The
// line store holds 2*RADIUS+1 rows of MAX_WIDTH pixels and needs no clearing.
// Config writes (cfg_ready always high) must only happen while the block idles.
module gaussian_blur_window_filter #(
	parameter int RADIUS     = gbwf_pkg::RADIUS_DEF,
	parameter int MAX_WIDTH  = gbwf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gbwf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config: index 0 width, 1 height, 2..7 coef_0..coef_5
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gbwf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [gbwf_pkg::COEF_W-1:0] cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [gbwf_pkg::PIX_W-1:0]  s_tdata,  // in_red, in_green, in_blue
	input  logic                        s_tuser,  // operation: 0 pixel, 1 flush
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [gbwf_pkg::PIX_W-1:0]  m_tdata,  // out_red, out_green, out_blue
	output logic                        m_tlast   // frame_last
);

	gbwf_pkg::cmd_t    cmd;
	gbwf_pkg::status_t status;

	assign cfg_ready = 1'b1;

	gbwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gbwf_datapath #(
		.RADIUS     (RADIUS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

FILE: src/gbwf_checker.sv
// ----------------------------------------------------------------------------
// gbwf_checker
// Port-level checks on the blur filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbwf_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready
);

	// stalled result word stays offered
	`GBWF_ASSERT_HOLD(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	// a result only appears after window computation, with input held off before it
	`GBWF_ASSERT(a_rise_busy, $rose(m_tvalid) |-> (!$past(s_tready, 1) && !$past(s_tready, 2) && !$past(s_tready, 3)), "result without computation")
	// one computation yields one word: taken word is not followed at once
	`GBWF_ASSERT(a_one_word, m_tvalid && m_tready |=> !m_tvalid, "result repeated")

endmodule

bind gaussian_blur_window_filter gbwf_checker u_gbwf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

FILE: tb/sv/gaussian_blur_window_filter_tb.sv
// ----------------------------------------------------------------------------
// gaussian_blur_window_filter_tb
// Self-checking bench for the streaming Gaussian blur window filter.
// ----------------------------------------------------------------------------
// Whole frames are pushed through the block under several register settings.
// A behavioral blur predictor runs on every accepted word and queues the pixel
// it expects. A monitor compares every result word with the oldest queued
// pixel. Both stream sides idle at random. Registers change only between
// frames, once the block has gone idle.
module gaussian_blur_window_filter_tb;
	import gbwf_pkg::*;

	localparam int RAD     = RADIUS_DEF;
	localparam int MAXW    = MAX_WIDTH_DEF;
	localparam int MAXH    = MAX_HEIGHT_DEF;
	localparam int RING    = (2 * RAD + 1) * MAXW;
	localparam int SETTLE  = (2 * RAD + 1) * (2 * RAD + 1) + 20;

	typedef struct {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} blur_px_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [PIX_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [PIX_W-1:0] m_tdata;
	logic m_tlast;

	gaussian_blur_window_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// predictor state: registers, pixel ring, positions
	logic [DIM_W-1:0]  width_reg  = WIDTH_RST;
	logic [DIM_W-1:0]  height_reg = HEIGHT_RST;
	logic [COEF_W-1:0] coef_reg [NCOEF] = '{COEF0_RST, COEF1_RST, COEF2_RST,
		COEF3_RST, COEF4_RST, COEF5_RST};
	logic [PIX_W-1:0]  pix_ring [RING];
	int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

	blur_px_t expected_px [$];
	int errors = 0;
	int words_sent = 0;
	bit calm = 0;        // no idling on either side while set

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $time, what);
		errors++;
	endtask

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned mx);
		if (v == 0) return 1;
		return (v > mx) ? mx : v;
	endfunction

	function automatic logic [CH_W-1:0] sat8(input logic [63:0] acc);
		logic [31:0] hi;
		hi = acc[63:32];
		return (hi > 255) ? 8'd255 : hi[7:0];
	endfunction

	// one accepted word; returns 1 when a pixel comes out
	function automatic bit blur_predict(input op_t op, input logic [PIX_W-1:0] pix,
		output blur_px_t res);
		int unsigned w, h, lag;
		bit emit;
		int y, x;
		logic [PIX_W-1:0] p;
		logic [63:0] wt, sr, sg, sb;
		w = clamp_dim(width_reg, MAXW);
		h = clamp_dim(height_reg, MAXH);
		lag = RAD * w + RAD;
		emit = 0;
		res = '{default: '0};
		if (in_row >= h && out_row >= h) begin
			in_col = 0; in_row = 0; out_col = 0; out_row = 0;
		end
		if (op == OP_PIXEL) begin
			if (in_row < h) begin
				pix_ring[(in_row * w + in_col) % RING] = pix;
				if (in_col + 1 >= w) begin
					in_col = 0; in_row++;
				end else in_col++;
				emit = out_row < h && (out_row * w + out_col) + lag < in_row * w + in_col;
			end
		end else
			emit = in_row >= h && out_row < h;
		if (!emit) return 0;
		sr = 0; sg = 0; sb = 0;
		for (int r = -RAD; r <= RAD; r++) begin
			y = int'(out_row) + r;
			if (y < 0 || y >= int'(h)) continue;
			for (int c = -RAD; c <= RAD; c++) begin
				x = int'(out_col) + c;
				if (x < 0 || x >= int'(w)) continue;
				p = pix_ring[(y * w + x) % RING];
				wt = 64'(coef_reg[r < 0 ? -r : r]) * 64'(coef_reg[c < 0 ? -c : c]);
				sr += 64'(p[7:0]) * wt;
				sg += 64'(p[15:8]) * wt;
				sb += 64'(p[23:16]) * wt;
			end
		end
		res.red = sat8(sr);
		res.green = sat8(sg);
		res.blue = sat8(sb);
		if (out_col + 1 >= w) begin
			out_col = 0; out_row++;
		end else out_col++;
		res.last = out_row >= h;
		if (res.last) begin
			in_col = 0; in_row = 0; out_col = 0; out_row = 0;
		end
		return 1;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int k;
		if (calm) return 0;
		k = $urandom_range(0, 99);
		if (k < 65) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 70);
	endfunction

	// receiver stalls
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// result monitor
	always @(posedge clk) begin
		blur_px_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_px.size() == 0)
				report_mismatch($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
			else begin
				e = expected_px.pop_front();
				if (m_tdata[7:0] !== e.red)
					report_mismatch($sformatf("red %h exp %h", m_tdata[7:0], e.red));
				if (m_tdata[15:8] !== e.green)
					report_mismatch($sformatf("green %h exp %h", m_tdata[15:8], e.green));
				if (m_tdata[23:16] !== e.blue)
					report_mismatch($sformatf("blue %h exp %h", m_tdata[23:16], e.blue));
				if (m_tlast !== e.last)
					report_mismatch($sformatf("tlast %b exp %b", m_tlast, e.last));
			end
		end
	end

	// one word on the input side; valid stays up across back-to-back words
	task automatic send_word(input op_t op, input logic [PIX_W-1:0] pix);
		int gap;
		blur_px_t res;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
		if (blur_predict(op, pix, res)) expected_px.push_back(res);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_px.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_WIDTH) width_reg = val[DIM_W-1:0];
		else if (idx == REG_HEIGHT) height_reg = val[DIM_W-1:0];
		else coef_reg[idx - REG_COEF0] = val;
		@(posedge clk);
	endtask

	task automatic set_dims(input int w, input int h);
		write_reg(REG_WIDTH, COEF_W'(w));
		write_reg(REG_HEIGHT, COEF_W'(h));
	endtask

	task automatic set_coefs(input int c0, c1, c2, c3, c4, c5);
		write_reg(REG_COEF0, COEF_W'(c0)); write_reg(REG_COEF1, COEF_W'(c1));
		write_reg(REG_COEF2, COEF_W'(c2)); write_reg(REG_COEF3, COEF_W'(c3));
		write_reg(REG_COEF4, COEF_W'(c4)); write_reg(REG_COEF5, COEF_W'(c5));
	endtask

	function automatic logic [PIX_W-1:0] rand_pix();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom());
		endcase
	endfunction

	// a full frame, then flush words until the last pixel has been predicted;
	// noisy frames add stray flushes mid-frame and pixels past the frame end
	task automatic run_frame(input bit noisy);
		int unsigned npix;
		npix = clamp_dim(width_reg, MAXW) * clamp_dim(height_reg, MAXH);
		for (int unsigned i = 0; i < npix; i++) begin
			if (noisy && $urandom_range(0, 19) == 0) send_word(OP_FLUSH, rand_pix());
			send_word(OP_PIXEL, rand_pix());
		end
		if (noisy) repeat ($urandom_range(0, 2)) send_word(OP_PIXEL, rand_pix());
		while (in_row >= clamp_dim(height_reg, MAXH)) send_word(OP_FLUSH, rand_pix());
		// nothing pending now: a flush is dropped
		if (noisy && $urandom_range(0, 1)) send_word(OP_FLUSH, rand_pix());
		wait_idle();
	endtask

	task automatic test_reset_defaults();
		// frame at reset coefficients; dims shrunk first so it stays short
		set_dims(5, 3);
		run_frame(0);
	endtask

	task automatic test_single_pixel();
		set_dims(0, 0);          // zero clamps to one
		run_frame(0);
		send_word(OP_FLUSH, '0); // flush before any pixel: dropped
		run_frame(1);
	endtask

	task automatic test_saturation();
		set_coefs(65535, 65535, 65535, 65535, 65535, 65535);
		set_dims(4, 4);
		run_frame(0);
	endtask

	task automatic test_zero_weights();
		set_coefs(0, 0, 0, 0, 0, 0);
		set_dims(3, 2);
		run_frame(0);
	endtask

	task automatic test_max_height();
		set_coefs(30000, 12000, 2500, 200, 65535, 65535);
		set_dims(1, 2047);       // clamps to the tallest frame
		run_frame(0);
	endtask

	task automatic test_random_frames();
		int stop_at;
		stop_at = words_sent + 150;
		while (words_sent < stop_at) begin
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 3) == 0)
				set_dims($urandom_range(0, 24), $urandom_range(0, 6));
			else
				set_dims($urandom_range(1, 12), $urandom_range(1, 8));
			if ($urandom_range(0, 1))
				set_coefs($urandom_range(20000, 40000), $urandom_range(8000, 20000),
					$urandom_range(1000, 6000), $urandom_range(0, 800),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			else
				set_coefs($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			run_frame($urandom_range(0, 2) != 0);
		end
		calm = 0;
	endtask

	initial begin
		#(12 * 2000000);
		$display("gaussian_blur_window_filter_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_single_pixel();
		test_saturation();
		test_zero_weights();
		test_max_height();
		test_random_frames();
		wait_idle();
		if (errors == 0)
			$display("gaussian_blur_window_filter_tb OK");
		else
			$display("gaussian_blur_window_filter_tb NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/gbwf_pkg.sv
src/gbwf_ctrl.sv
src/gbwf_datapath.sv
src/gaussian_blur_window_filter.sv
src/gbwf_checker.sv
tb/sv/gaussian_blur_window_filter_tb.sv
